/* sv/tanh_pkg.sv */
// tanh_pkg: shared constants and types for the tanh activation unit.
// Depends on nothing; every other file of the block uses it.

package tanh_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 16;

  // U1.62 arithmetic: 1.0 = 2^62
  localparam int unsigned FRAC_W = 62;
  localparam int unsigned TERM_W = FRAC_W + 1;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned HALF_W = 32;

  localparam logic [ACC_W-1:0]  ONE      = 64'h4000_0000_0000_0000;
  localparam logic [TERM_W-1:0] ONE_TERM = ONE[TERM_W-1:0];

  localparam int unsigned TAYLOR_TERMS = 24;
  localparam int unsigned SQUARINGS    = 5;

  // division of a series term by its index, 16 bits a stage
  localparam int unsigned CHUNK_W     = 16;
  localparam int unsigned NUM_CHUNKS  = ACC_W / CHUNK_W;
  localparam int unsigned REM_W       = 5;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

  typedef struct packed {
    logic valid;
    logic neg;
    logic last;
  } tanh_ctl_t;

endpackage

/* sv/tanh_if.sv */
// tanh_if: valid/ready channel interfaces for the tanh activation unit.
// Depends on tanh_pkg for the default data width.

interface tanh_in_if #(
  parameter int unsigned DATA_WIDTH = tanh_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_value;
  logic                         last_in;

  modport source (output valid, output x_value, output last_in, input ready);
  modport sink   (input valid, input x_value, input last_in, output ready);
endinterface

interface tanh_out_if #(
  parameter int unsigned DATA_WIDTH = tanh_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] y_value;
  logic                         last_out;

  modport source (output valid, output y_value, output last_out, input ready);
  modport sink   (input valid, input y_value, input last_out, output ready);
endinterface

/* sv/tanh_series_cell.sv */
// tanh_series_cell: one term of the e^-u series, term = (term * m >> W) / K,
// accumulated with alternating sign. Eight register stages.
// Depends on tanh_pkg.

module tanh_series_cell #(
  parameter int unsigned DATA_WIDTH = tanh_pkg::DATA_WIDTH_DEF,
  parameter int unsigned K          = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  tanh_pkg::tanh_ctl_t         ctl_i,
  input  logic [DATA_WIDTH-1:0]       m_i,
  input  logic [tanh_pkg::TERM_W-1:0] term_i,
  input  logic [tanh_pkg::ACC_W-1:0]  e_i,
  output tanh_pkg::tanh_ctl_t         ctl_o,
  output logic [DATA_WIDTH-1:0]       m_o,
  output logic [tanh_pkg::TERM_W-1:0] term_o,
  output logic [tanh_pkg::ACC_W-1:0]  e_o
);

  localparam int unsigned TW    = tanh_pkg::TERM_W;
  localparam int unsigned AW    = tanh_pkg::ACC_W;
  localparam int unsigned HW    = tanh_pkg::HALF_W;
  localparam int unsigned HI_W  = TW - HW;
  localparam int unsigned PLO_W = HW + DATA_WIDTH;
  localparam int unsigned PHI_W = HI_W + DATA_WIDTH;
  localparam int unsigned SUM_W = AW + DATA_WIDTH;
  localparam int unsigned CW    = tanh_pkg::CHUNK_W;
  localparam int unsigned NC    = tanh_pkg::NUM_CHUNKS;
  localparam int unsigned RW    = tanh_pkg::REM_W;
  localparam int unsigned NUM_W = RW + CW;
  localparam int unsigned RCP_W = tanh_pkg::RECIP_W;
  localparam int unsigned PRD_W = NUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((65'd1 << tanh_pkg::RECIP_SHIFT) + 65'(K) - 65'd1) / 65'(K));
  localparam logic [NUM_W-1:0] K_NUM = NUM_W'(K);
  localparam bit K_ODD = (K % 2) == 1;

  // stage a: low partial product
  tanh_pkg::tanh_ctl_t   ctl_a_r;
  logic [DATA_WIDTH-1:0] m_a_r;
  logic [HI_W-1:0]       hi_a_r;
  logic [PLO_W-1:0]      plo_a_r;
  logic [AW-1:0]         e_a_r;

  // stage b: high partial product
  tanh_pkg::tanh_ctl_t   ctl_b_r;
  logic [DATA_WIDTH-1:0] m_b_r;
  logic [PLO_W-1:0]      plo_b_r;
  logic [PHI_W-1:0]      phi_b_r;
  logic [AW-1:0]         e_b_r;

  // division stages, index 0 holds the full dividend
  tanh_pkg::tanh_ctl_t   ctl_d_r [NC+1];
  logic [DATA_WIDTH-1:0] m_d_r   [NC+1];
  logic [AW-1:0]         e_d_r   [NC+1];
  logic [AW-1:0]         w_d_r   [NC+1];
  logic [RW-1:0]         rem_d_r [NC+1];

  // final stage
  tanh_pkg::tanh_ctl_t   ctl_f_r;
  logic [DATA_WIDTH-1:0] m_f_r;
  logic [TW-1:0]         term_f_r;
  logic [AW-1:0]         e_f_r;

  logic [SUM_W-1:0]      sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_d_r[0] <= '0;
      ctl_f_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
      ctl_d_r[0] <= ctl_b_r;
      ctl_f_r <= ctl_d_r[NC];
    end
  end

  assign sum = (SUM_W'(phi_b_r) << HW) + SUM_W'(plo_b_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m_a_r   <= m_i;
      hi_a_r  <= term_i[TW-1:HW];
      plo_a_r <= PLO_W'(term_i[HW-1:0]) * PLO_W'(m_i);
      e_a_r   <= e_i;

      m_b_r   <= m_a_r;
      plo_b_r <= plo_a_r;
      phi_b_r <= PHI_W'(hi_a_r) * PHI_W'(m_a_r);
      e_b_r   <= e_a_r;

      m_d_r[0]   <= m_b_r;
      e_d_r[0]   <= e_b_r;
      w_d_r[0]   <= sum[DATA_WIDTH +: AW];
      rem_d_r[0] <= '0;

      m_f_r    <= m_d_r[NC];
      term_f_r <= w_d_r[NC][TW-1:0];
      e_f_r    <= K_ODD ? (e_d_r[NC] - w_d_r[NC]) : (e_d_r[NC] + w_d_r[NC]);
    end
  end

  for (genvar j = 0; j < NC; j++) begin : g_div
    localparam int unsigned LSB = AW - (j + 1) * CW;
    logic [NUM_W-1:0] num;
    logic [PRD_W-1:0] prod;
    logic [CW-1:0]    q;
    logic [NUM_W-1:0] diff;
    logic [AW-1:0]    w_nxt;

    // reciprocal is exact for num < 2^21 and K < 32
    always_comb begin
      num   = {rem_d_r[j], w_d_r[j][LSB +: CW]};
      prod  = PRD_W'(num) * PRD_W'(RECIP);
      q     = prod[tanh_pkg::RECIP_SHIFT +: CW];
      diff  = num - NUM_W'(NUM_W'(q) * K_NUM);
      w_nxt = w_d_r[j];
      w_nxt[LSB +: CW] = q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_d_r[j+1] <= '0;
      end else if (en) begin
        ctl_d_r[j+1] <= ctl_d_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_d_r[j+1]   <= m_d_r[j];
        e_d_r[j+1]   <= e_d_r[j];
        w_d_r[j+1]   <= w_nxt;
        rem_d_r[j+1] <= diff[RW-1:0];
      end
    end
  end

  assign ctl_o  = ctl_f_r;
  assign m_o    = m_f_r;
  assign term_o = term_f_r;
  assign e_o    = e_f_r;

endmodule

/* sv/tanh_square_cell.sv */
// tanh_square_cell: t = (t * t) >> 62 from three partial products of the 31-bit high
// and 32-bit low halves of t, four register stages.
// Depends on tanh_pkg.

module tanh_square_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  tanh_pkg::tanh_ctl_t         ctl_i,
  input  logic [tanh_pkg::TERM_W-1:0] t_i,
  output tanh_pkg::tanh_ctl_t         ctl_o,
  output logic [tanh_pkg::TERM_W-1:0] t_o
);

  localparam int unsigned TW     = tanh_pkg::TERM_W;
  localparam int unsigned HW     = tanh_pkg::HALF_W;
  localparam int unsigned HI_W   = TW - HW;
  localparam int unsigned LL_W   = 2 * HW;
  localparam int unsigned HL_W   = HI_W + HW;
  localparam int unsigned HH_W   = 2 * HI_W;
  localparam int unsigned ACC_XW = HL_W + HW + 2;
  localparam int unsigned FULL_W = 2 * TW + 1;

  tanh_pkg::tanh_ctl_t ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r;
  logic [HI_W-1:0]     th_a_r, th_b_r;
  logic [HW-1:0]       tl_a_r;
  logic [LL_W-1:0]     ll_a_r, ll_b_r;
  logic [HL_W-1:0]     hl_b_r;
  logic [HH_W-1:0]     hh_c_r;
  logic [ACC_XW-1:0]   acc_c_r;
  logic [TW-1:0]       t_d_r;
  logic [FULL_W-1:0]   full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
    end
  end

  assign full = (FULL_W'(hh_c_r) << LL_W) + FULL_W'(acc_c_r);

  always_ff @(posedge clk) begin
    if (en) begin
      th_a_r  <= t_i[TW-1:HW];
      tl_a_r  <= t_i[HW-1:0];
      ll_a_r  <= LL_W'(t_i[HW-1:0]) * LL_W'(t_i[HW-1:0]);

      th_b_r  <= th_a_r;
      ll_b_r  <= ll_a_r;
      hl_b_r  <= HL_W'(th_a_r) * HL_W'(tl_a_r);

      hh_c_r  <= HH_W'(th_b_r) * HH_W'(th_b_r);
      acc_c_r <= (ACC_XW'(hl_b_r) << (HW + 1)) + ACC_XW'(ll_b_r);

      t_d_r   <= full[tanh_pkg::FRAC_W +: TW];
    end
  end

  assign ctl_o = ctl_d_r;
  assign t_o   = t_d_r;

endmodule

/* sv/tanh_div_cell.sv */
// tanh_div_cell: one quotient bit of the restoring division (1 - t) / (1 + t).
// Depends on tanh_pkg.

module tanh_div_cell #(
  parameter int unsigned DATA_WIDTH = tanh_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  tanh_pkg::tanh_ctl_t        ctl_i,
  input  logic [tanh_pkg::ACC_W-1:0] rem_i,
  input  logic [tanh_pkg::ACC_W-1:0] den_i,
  input  logic [DATA_WIDTH-2:0]      quo_i,
  output tanh_pkg::tanh_ctl_t        ctl_o,
  output logic [tanh_pkg::ACC_W-1:0] rem_o,
  output logic [tanh_pkg::ACC_W-1:0] den_o,
  output logic [DATA_WIDTH-2:0]      quo_o
);

  localparam int unsigned AW = tanh_pkg::ACC_W;
  localparam int unsigned QW = DATA_WIDTH - 1;

  tanh_pkg::tanh_ctl_t ctl_r;
  logic [AW-1:0]       rem_r, den_r;
  logic [QW-1:0]       quo_r;
  logic [AW-1:0]       sh;
  logic                ge;

  assign sh = {rem_i[AW-2:0], 1'b0};
  assign ge = (sh >= den_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? (sh - den_i) : sh;
      den_r <= den_i;
      quo_r <= {quo_i[QW-2:0], ge};
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule

/* sv/tanh_activation_unit.sv */
// tanh_activation_unit: y = tanh(x), x signed Q4.(W-4) in, y signed Q2.(W-2) out, rounded to
// nearest. Depends on tanh_pkg, tanh_if, tanh_series_cell, tanh_square_cell, tanh_div_cell.
//
// Takes one word per clock and returns one word per clock, sustained while out_chan.ready
// stays high. The datapath is a fully pipelined row of cells: 23 series cells of 8 stages
// each (split product, then a division by the term index 16 bits a stage), 5 squaring
// cells of 4 stages, one setup stage and DATA_WIDTH-1 one-bit division cells. A two-word
// output buffer sits after the pipeline; the input stalls only while both of its entries
// are held. last_in travels with its word and comes out as last_out. No result depends on
// an earlier word.

module tanh_activation_unit #(
  parameter int unsigned DATA_WIDTH = tanh_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tanh_in_if.sink   in_chan,
  tanh_out_if.source out_chan
);

  localparam int unsigned TW    = tanh_pkg::TERM_W;
  localparam int unsigned AW    = tanh_pkg::ACC_W;
  localparam int unsigned QW    = DATA_WIDTH - 1;
  localparam int unsigned N_SER = tanh_pkg::TAYLOR_TERMS - 1;
  localparam int unsigned N_SQ  = tanh_pkg::SQUARINGS;

  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_ONE   = 2'd1;
  localparam logic [1:0] BUF_FULL  = 2'd2;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] y;
    logic                  last;
  } out_word_t;

  logic en;

  // input stage
  tanh_pkg::tanh_ctl_t   ctl_in_r;
  logic [DATA_WIDTH-1:0] m_in_r;
  logic [DATA_WIDTH-1:0] x_bits;
  logic                  x_neg;

  // series chain
  tanh_pkg::tanh_ctl_t   ser_ctl  [N_SER+1];
  logic [DATA_WIDTH-1:0] ser_m    [N_SER+1];
  logic [TW-1:0]         ser_term [N_SER+1];
  logic [AW-1:0]         ser_e    [N_SER+1];

  // squaring chain
  tanh_pkg::tanh_ctl_t   sq_ctl [N_SQ+1];
  logic [TW-1:0]         sq_t   [N_SQ+1];

  // division setup
  tanh_pkg::tanh_ctl_t   prep_ctl_r;
  logic [AW-1:0]         prep_num_r, prep_den_r;
  logic [AW-1:0]         t_clamp;

  // division chain
  tanh_pkg::tanh_ctl_t   dv_ctl [QW+1];
  logic [AW-1:0]         dv_rem [QW+1];
  logic [AW-1:0]         dv_den [QW+1];
  logic [QW-1:0]         dv_quo [QW+1];

  // output
  logic [DATA_WIDTH-1:0] mag, y_fin;
  out_word_t             word_fin;
  logic                  push, pop;
  logic [1:0]            cnt_r, cnt_nxt;
  out_word_t             head_r, head_nxt, tail_r, tail_nxt;

  assign en            = (cnt_r != BUF_FULL);
  assign in_chan.ready = en;

  assign x_bits = in_chan.x_value;
  assign x_neg  = x_bits[DATA_WIDTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_in_r <= '0;
    end else if (en) begin
      ctl_in_r.valid <= in_chan.valid;
      ctl_in_r.neg   <= x_neg;
      ctl_in_r.last  <= in_chan.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_in_r <= x_neg ? (~x_bits + 1'b1) : x_bits;
    end
  end

  assign ser_ctl[0]  = ctl_in_r;
  assign ser_m[0]    = m_in_r;
  assign ser_term[0] = tanh_pkg::ONE_TERM;
  assign ser_e[0]    = tanh_pkg::ONE;

  for (genvar i = 0; i < N_SER; i++) begin : g_ser
    tanh_series_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .K          (i + 1)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ser_ctl[i]),
      .m_i    (ser_m[i]),
      .term_i (ser_term[i]),
      .e_i    (ser_e[i]),
      .ctl_o  (ser_ctl[i+1]),
      .m_o    (ser_m[i+1]),
      .term_o (ser_term[i+1]),
      .e_o    (ser_e[i+1])
    );
  end

  assign sq_ctl[0] = ser_ctl[N_SER];
  assign sq_t[0]   = ser_e[N_SER][TW-1:0];

  for (genvar i = 0; i < N_SQ; i++) begin : g_sq
    tanh_square_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (sq_ctl[i]),
      .t_i   (sq_t[i]),
      .ctl_o (sq_ctl[i+1]),
      .t_o   (sq_t[i+1])
    );
  end

  assign t_clamp = (sq_t[N_SQ] > tanh_pkg::ONE_TERM) ? tanh_pkg::ONE : AW'(sq_t[N_SQ]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_ctl_r <= '0;
    end else if (en) begin
      prep_ctl_r <= sq_ctl[N_SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_num_r <= tanh_pkg::ONE - t_clamp;
      prep_den_r <= tanh_pkg::ONE + t_clamp;
    end
  end

  assign dv_ctl[0] = prep_ctl_r;
  assign dv_rem[0] = prep_num_r;
  assign dv_den[0] = prep_den_r;
  assign dv_quo[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    tanh_div_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (dv_ctl[i]),
      .rem_i (dv_rem[i]),
      .den_i (dv_den[i]),
      .quo_i (dv_quo[i]),
      .ctl_o (dv_ctl[i+1]),
      .rem_o (dv_rem[i+1]),
      .den_o (dv_den[i+1]),
      .quo_o (dv_quo[i+1])
    );
  end

  // round half up, then restore the sign
  assign mag   = (DATA_WIDTH'(dv_quo[QW]) + DATA_WIDTH'(1)) >> 1;
  assign y_fin = dv_ctl[QW].neg ? (~mag + 1'b1) : mag;

  assign word_fin.y    = y_fin;
  assign word_fin.last = dv_ctl[QW].last;

  assign push = en && dv_ctl[QW].valid;
  assign pop  = (cnt_r != BUF_EMPTY) && out_chan.ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    unique case (cnt_r)
      BUF_EMPTY: begin
        if (push) begin
          head_nxt = word_fin;
          cnt_nxt  = BUF_ONE;
        end
      end
      BUF_ONE: begin
        priority if (push && pop) begin
          head_nxt = word_fin;
        end else if (push) begin
          tail_nxt = word_fin;
          cnt_nxt  = BUF_FULL;
        end else if (pop) begin
          cnt_nxt  = BUF_EMPTY;
        end
      end
      BUF_FULL: begin
        if (pop) begin
          head_nxt = tail_r;
          cnt_nxt  = BUF_ONE;
        end
      end
      default: begin
        cnt_nxt = BUF_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= BUF_EMPTY;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_chan.valid    = (cnt_r != BUF_EMPTY);
  assign out_chan.y_value  = head_r.y;
  assign out_chan.last_out = head_r.last;

endmodule

/* sv/tanh_chk.sv */
// tanh_chk: port-level checks for tanh_activation_unit, bound to the top level.
// Depends on tanh_pkg and tanh_activation_unit.

module tanh_chk #(
  parameter int unsigned DATA_WIDTH = tanh_pkg::DATA_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] out_y,
  input logic                         out_last
);

  localparam logic signed [DATA_WIDTH-1:0] Y_MAX =
    DATA_WIDTH'(longint'(1) << (DATA_WIDTH - 2));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_y) && $stable(out_last))
    else $error("result word changed while stalled");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_y <= Y_MAX) && (out_y >= -Y_MAX))
    else $error("tanh result beyond +-1.0");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && in_valid |-> $past(out_valid) && !$past(out_ready))
    else $error("input stalled without a held result");

endmodule

bind tanh_activation_unit tanh_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_tanh_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_y     (out_chan.y_value),
  .out_last  (out_chan.last_out)
);
